### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRLT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DRLT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/drlt_pkg.sv
// ============================================================================
// drlt_pkg
// Shared types and constants of the consumer read-limit tracker.
// ============================================================================
`timescale 1ns / 1ps

package drlt_pkg;

    // Default number of consumer entries.
    localparam int CONSUMERS_DEF = 8;

    // Fixed field widths.
    localparam int ACTION_W    = 2;
    localparam int CONSUMER_W  = 3;
    localparam int CURSOR_W    = 64;
    localparam int DEP_W       = 4;
    localparam int CAP_W       = 63;
    localparam int RING_LOG2_W = 6;

    // Reset value of the ring size register and its saturating code.
    localparam logic [RING_LOG2_W-1:0] RING_LOG2_RST = 6'd10;
    localparam logic [RING_LOG2_W-1:0] RING_LOG2_SAT = 6'd63;

    // Limit advance applied at every update.
    localparam logic [CURSOR_W-1:0] LIMIT_STEP = 64'h1000_0000_0000_0000;

    // Action codes of an input transaction.
    typedef logic [ACTION_W-1:0] action_t;
    localparam action_t ACT_WR_CURSOR = 2'd0;
    localparam action_t ACT_WR_DEPS   = 2'd1;
    localparam action_t ACT_UPDATE    = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_VISIT,
        ST_RESULT
    } state_t;

endpackage

### rtl/core/drlt_if.sv
// ============================================================================
// drlt_if
// Valid/ready channels for input and result transactions.
// ============================================================================
`timescale 1ns / 1ps

interface drlt_item_if;
    import drlt_pkg::*;

    logic                  valid;
    logic                  ready;
    action_t               action;
    logic [CONSUMER_W-1:0] consumer;
    logic [CURSOR_W-1:0]   cursor_value;
    logic [DEP_W-1:0]      dep_first;
    logic [DEP_W-1:0]      dep_last;

    modport source (
        output valid, action, consumer, cursor_value, dep_first, dep_last,
        input  ready
    );

    modport sink (
        input  valid, action, consumer, cursor_value, dep_first, dep_last,
        output ready
    );
endinterface

interface drlt_result_if;
    import drlt_pkg::*;

    logic                valid;
    logic                ready;
    logic [CAP_W-1:0]    capacity;
    logic [CURSOR_W-1:0] limit_value;

    modport source (
        output valid, capacity, limit_value,
        input  ready
    );

    modport sink (
        input  valid, capacity, limit_value,
        output ready
    );
endinterface

### rtl/core/dependency_read_limit_tracker.sv
// ============================================================================
// dependency_read_limit_tracker
// Cursor and range write transactions are accepted without producing a result.
// An update reads its own entry, then walks its range downwards: each entry
// visited takes a memory read (ST_WALK, then ST_VISIT), and out-of-range indices
// are skipped in ST_WALK without a read; an empty range goes straight to ST_RESULT.
// The next transaction is accepted from the cycle the result appears.
// Reset clears the per-entry valid bits, so all tables read zero; ring size log2 10.
// ============================================================================
`timescale 1ns / 1ps

module dependency_read_limit_tracker #(
    parameter int CONSUMERS = drlt_pkg::CONSUMERS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [drlt_pkg::RING_LOG2_W-1:0] cfg_wr_data,
    drlt_item_if.sink                        item,
    drlt_result_if.source                    result
);
    import drlt_pkg::*;

    localparam int IDX_W = (CONSUMERS > 1) ? $clog2(CONSUMERS) : 1;

    // Configuration.
    logic [RING_LOG2_W-1:0] ring_log2_reg;

    // Entry memories and their valid bits.
    logic [CURSOR_W-1:0]  cur_mem [CONSUMERS];
    logic [CURSOR_W-1:0]  rl_mem  [CONSUMERS];
    logic [2*DEP_W-1:0]   dep_mem [CONSUMERS];
    logic [CONSUMERS-1:0] cur_vld_reg;
    logic [CONSUMERS-1:0] rl_vld_reg;
    logic [CONSUMERS-1:0] dep_vld_reg;

    // Registered read data.
    logic [CURSOR_W-1:0] cur_rd_reg;
    logic [CURSOR_W-1:0] rl_rd_reg;
    logic [2*DEP_W-1:0]  dep_rd_reg;
    logic                cur_hit_reg;
    logic                rl_hit_reg;
    logic                dep_hit_reg;
    logic [CURSOR_W-1:0] cur_q;
    logic [CURSOR_W-1:0] rl_q;
    logic [DEP_W-1:0]    dep_first_q;
    logic [DEP_W-1:0]    dep_last_q;

    // Sequencer state and working registers.
    state_t              state_reg,   state_next;
    logic [IDX_W-1:0]    c_reg,       c_next;
    logic [DEP_W-1:0]    i_reg,       i_next;
    logic [DEP_W-1:0]    first_reg,   first_next;
    logic [CURSOR_W-1:0] limit_reg,   limit_next;
    logic [CURSOR_W-1:0] own_cur_reg, own_cur_next;
    logic [CAP_W-1:0]    cap_reg,     cap_next;

    // Output register.
    logic                out_valid_reg;
    logic [CAP_W-1:0]    out_cap_reg;
    logic [CURSOR_W-1:0] out_limit_reg;

    // Control signals.
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                rl_wr_en;
    logic                load_out;
    logic                in_fire;
    logic                in_cons_ok;
    logic [IDX_W-1:0]    in_addr;
    logic [DEP_W-1:0]    walk_idx;
    logic [CURSOR_W-1:0] cap_diff;
    logic [CURSOR_W-1:0] before_diff;
    logic [CAP_W-1:0]    empty_cap;

    // Input decode.
    assign in_fire    = item.valid && item.ready;
    assign in_cons_ok = (int'(item.consumer) < CONSUMERS);
    assign in_addr    = IDX_W'(item.consumer);

    // Entries never written read as zero.
    assign cur_q       = cur_hit_reg ? cur_rd_reg : '0;
    assign rl_q        = rl_hit_reg ? rl_rd_reg : '0;
    assign dep_first_q = dep_hit_reg ? dep_rd_reg[2*DEP_W-1:DEP_W] : '0;
    assign dep_last_q  = dep_hit_reg ? dep_rd_reg[DEP_W-1:0] : '0;

    // Datapath terms.
    assign walk_idx    = i_reg - DEP_W'(1);
    assign cap_diff    = limit_reg - own_cur_reg;
    assign before_diff = cur_q - limit_reg;
    assign empty_cap   = (ring_log2_reg == RING_LOG2_SAT) ? {CAP_W{1'b1}}
                                                          : (CAP_W'(1) << ring_log2_reg);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_log2_reg <= RING_LOG2_RST;
        end
        else if (cfg_wr_en)
        begin
            ring_log2_reg <= cfg_wr_data;
        end
    end

    // Memory writes.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_cons_ok && item.action == ACT_WR_CURSOR)
        begin
            cur_mem[in_addr] <= item.cursor_value;
        end
        if (in_fire && in_cons_ok && item.action == ACT_WR_DEPS)
        begin
            dep_mem[in_addr] <= {item.dep_first, item.dep_last};
        end
        if (rl_wr_en)
        begin
            rl_mem[c_reg] <= limit_reg;
        end
    end

    // Memory reads, one address shared by all three memories.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cur_rd_reg <= cur_mem[rd_addr];
            rl_rd_reg  <= rl_mem[rd_addr];
            dep_rd_reg <= dep_mem[rd_addr];
        end
    end

    // Valid bits and the hit flags that go with the read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_vld_reg <= '0;
            rl_vld_reg  <= '0;
            dep_vld_reg <= '0;
            cur_hit_reg <= 1'b0;
            rl_hit_reg  <= 1'b0;
            dep_hit_reg <= 1'b0;
        end
        else
        begin
            if (in_fire && in_cons_ok && item.action == ACT_WR_CURSOR)
            begin
                cur_vld_reg[in_addr] <= 1'b1;
            end
            if (in_fire && in_cons_ok && item.action == ACT_WR_DEPS)
            begin
                dep_vld_reg[in_addr] <= 1'b1;
            end
            if (rl_wr_en)
            begin
                rl_vld_reg[c_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                cur_hit_reg <= cur_vld_reg[rd_addr];
                rl_hit_reg  <= rl_vld_reg[rd_addr];
                dep_hit_reg <= dep_vld_reg[rd_addr];
            end
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers of the update walk.
    always_ff @(posedge clk)
    begin
        c_reg       <= c_next;
        i_reg       <= i_next;
        first_reg   <= first_next;
        limit_reg   <= limit_next;
        own_cur_reg <= own_cur_next;
        cap_reg     <= cap_next;
    end

    // Next state and control.
    always_comb
    begin
        state_next   = state_reg;
        c_next       = c_reg;
        i_next       = i_reg;
        first_next   = first_reg;
        limit_next   = limit_reg;
        own_cur_next = own_cur_reg;
        cap_next     = cap_reg;
        rd_en        = 1'b0;
        rd_addr      = c_reg;
        rl_wr_en     = 1'b0;
        load_out     = 1'b0;
        item.ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Writes complete here; an update starts by reading its own entry.
                item.ready = 1'b1;
                if (item.valid && in_cons_ok && item.action == ACT_UPDATE)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = in_addr;
                    c_next     = in_addr;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                limit_next   = rl_q + LIMIT_STEP;
                own_cur_next = cur_q;
                first_next   = dep_first_q;
                i_next       = dep_last_q;
                if (dep_first_q >= dep_last_q)
                begin
                    cap_next   = empty_cap;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // Step down one index; entries outside the table are skipped.
                if (i_reg > first_reg)
                begin
                    i_next = walk_idx;
                    if (int'(walk_idx) < CONSUMERS)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = IDX_W'(walk_idx);
                        state_next = ST_VISIT;
                    end
                end
                else
                begin
                    cap_next   = cap_diff[CURSOR_W-1] ? '0 : cap_diff[CAP_W-1:0];
                    state_next = ST_RESULT;
                end
            end
            ST_VISIT:
            begin
                // Keep the earliest cursor and follow the entry's own range down.
                if (before_diff[CURSOR_W-1])
                begin
                    limit_next = cur_q;
                end
                if (dep_last_q >= i_reg && dep_first_q < i_reg)
                begin
                    i_next = dep_first_q;
                end
                state_next = ST_WALK;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    rl_wr_en   = 1'b1;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_cap_reg   <= cap_reg;
            out_limit_reg <= limit_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.capacity    = out_cap_reg;
    assign result.limit_value = out_limit_reg;

endmodule

### rtl/core/drlt_checker.sv
// ============================================================================
// drlt_checker
// Port-level assertions on the read-limit tracker, attached by bind.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module drlt_checker #(
    parameter int CONSUMERS = drlt_pkg::CONSUMERS_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            item_valid,
    input logic                            item_ready,
    input drlt_pkg::action_t               item_action,
    input logic [drlt_pkg::CONSUMER_W-1:0] item_consumer,
    input logic                            result_valid,
    input logic                            result_ready,
    input logic [drlt_pkg::CAP_W-1:0]      result_capacity,
    input logic [drlt_pkg::CURSOR_W-1:0]   result_limit_value
);
    import drlt_pkg::*;

    // A stalled result transaction keeps its payload.
    `DRLT_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_capacity) && $stable(result_limit_value), "result changed while stalled")

    // An accepted update closes the input: ready is low once the update is taken.
    `DRLT_ASSERT_NXT(a_update_busy, clk, rst_n, item_valid && item_ready && item_action == ACT_UPDATE && int'(item_consumer) < CONSUMERS, !item_ready, "input open during update")

    // Cursor and range writes leave the input open.
    `DRLT_ASSERT_NXT(a_write_single, clk, rst_n, item_valid && item_ready && (item_action == ACT_WR_CURSOR || item_action == ACT_WR_DEPS), item_ready, "write held the input")

endmodule

bind dependency_read_limit_tracker drlt_checker #(
    .CONSUMERS(CONSUMERS)
) u_drlt_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item.valid),
    .item_ready         (item.ready),
    .item_action        (item.action),
    .item_consumer      (item.consumer),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_capacity    (result.capacity),
    .result_limit_value (result.limit_value)
);
